/* rtl/core/gvns_pkg.sv */
// Shared types and constants of the grid vertex normal stream unit.
// Used by gvns_ring, gvns_norm and the top level; depends on nothing.
package gvns_pkg;

	localparam int COORD_W = 24;
	localparam int EDGE_W  = 25;
	localparam int SUM_W   = 52;
	localparam int R_W     = 31;
	localparam int ROOT_W  = 32;
	localparam int NRM_W   = 16;
	localparam int VNUM_W  = 16;
	localparam int FILL_W  = 8;
	localparam int RL_W    = 6;
	localparam int QUO_W   = 15;

	localparam logic [RL_W-1:0]   ROW_LEN_RESET = 6'd32;
	localparam logic [FILL_W-1:0] FILL_MAX      = 8'd255;
	localparam logic [QUO_W-1:0]  ONE_Q14       = 15'd16384;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;
	typedef logic signed [NRM_W-1:0]   nrm_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} coord3_t;

	typedef struct packed {
		edge_t x;
		edge_t y;
		edge_t z;
	} edge3_t;

	typedef struct packed {
		nrm_t x;
		nrm_t y;
		nrm_t z;
	} nrm3_t;

endpackage

/* rtl/core/gvns_ring.sv */
// Ring store of the most recent vertices, one write and one registered read port.
// Depends on gvns_pkg for the coordinate types.
module gvns_ring #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  gvns_pkg::coord3_t wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output gvns_pkg::coord3_t rd_data
);

	gvns_pkg::coord3_t mem_q [DEPTH];
	gvns_pkg::coord3_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/gvns_norm.sv */
// Shared arithmetic unit: cross product, magnitude scaling, square root and
// the three divisions of one normal, with one multiplier. Depends on gvns_pkg.
module gvns_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  gvns_pkg::edge3_t a_vec,
	input  gvns_pkg::edge3_t b_vec,
	output logic             done,
	output gvns_pkg::nrm3_t  result
);

	localparam int SW = gvns_pkg::SUM_W;
	localparam int RW = gvns_pkg::R_W;
	localparam int NW = gvns_pkg::ROOT_W;
	localparam int QW = gvns_pkg::QUO_W;
	localparam int NUM_W = RW + 14 + 1;

	typedef enum logic [8:0] {
		N_IDLE  = 9'b000000001,
		N_CROSS = 9'b000000010,
		N_ABS   = 9'b000000100,
		N_SHIFT = 9'b000001000,
		N_SQ    = 9'b000010000,
		N_SQRT  = 9'b000100000,
		N_DLOAD = 9'b001000000,
		N_DSTEP = 9'b010000000,
		N_DONE  = 9'b100000000
	} nstate_t;

	nstate_t state_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;

	gvns_pkg::edge_t av_q [3];
	gvns_pkg::edge_t bv_q [3];
	logic signed [SW-1:0] s_q [3];
	logic [SW-1:0] mag_q [3];
	logic neg_q [3];
	logic signed [63:0] prod_q;
	logic [63:0] q_q;
	logic [33:0] rem_q;
	logic [NW-1:0] root_q;
	logic [NUM_W-1:0] num_q;
	logic [NW-1:0] drem_q;
	logic [QW-2:0] quo_q;
	gvns_pkg::nrm_t res_q [3];

	logic signed [31:0] ma, mb;
	logic [2:0] jj;
	logic [1:0] acc_idx;
	logic big;
	logic [35:0] rem2, trial;
	logic [RW-1:0] rsel;
	logic [NUM_W-1:0] numer;
	logic [NW:0] drem2;
	logic qbit;
	logic [QW-1:0] qf, qc;

	// Operand selection for the one multiplier.
	always_comb begin
		ma = '0;
		mb = '0;
		if (state_q == N_CROSS) begin
			case (cnt_q[2:0])
				3'd0: begin ma = 32'(av_q[1]); mb = 32'(bv_q[2]); end
				3'd1: begin ma = 32'(av_q[2]); mb = 32'(bv_q[1]); end
				3'd2: begin ma = 32'(av_q[2]); mb = 32'(bv_q[0]); end
				3'd3: begin ma = 32'(av_q[0]); mb = 32'(bv_q[2]); end
				3'd4: begin ma = 32'(av_q[0]); mb = 32'(bv_q[1]); end
				3'd5: begin ma = 32'(av_q[1]); mb = 32'(bv_q[0]); end
				default: begin ma = '0; mb = '0; end
			endcase
		end else begin
			case (cnt_q[1:0])
				2'd0: ma = {1'b0, mag_q[0][RW-1:0]};
				2'd1: ma = {1'b0, mag_q[1][RW-1:0]};
				2'd2: ma = {1'b0, mag_q[2][RW-1:0]};
				default: ma = '0;
			endcase
			mb = ma;
		end
	end

	always_comb begin
		jj = cnt_q[2:0] - 3'd1;
		acc_idx = jj[2:1];
		big = (mag_q[0][SW-1:RW] != '0) || (mag_q[1][SW-1:RW] != '0) ||
			(mag_q[2][SW-1:RW] != '0);
		rem2 = {rem_q, q_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		case (comp_q)
			2'd0: rsel = mag_q[0][RW-1:0];
			2'd1: rsel = mag_q[1][RW-1:0];
			default: rsel = mag_q[2][RW-1:0];
		endcase
		numer = NUM_W'({rsel, 14'b0}) + NUM_W'(root_q >> 1);
		drem2 = {drem_q, num_q[QW-1]};
		qbit = drem2 >= {1'b0, root_q};
		qf = {quo_q, qbit};
		qc = (qf > gvns_pkg::ONE_Q14) ? gvns_pkg::ONE_Q14 : qf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q <= '0;
			comp_q <= '0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_CROSS;
						cnt_q <= '0;
					end
				end
				N_CROSS: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd6) begin
						state_q <= N_ABS;
					end
				end
				N_ABS: begin
					if (s_q[0] == '0 && s_q[1] == '0 && s_q[2] == '0) begin
						state_q <= N_DONE;
					end else begin
						state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (!big) begin
						state_q <= N_SQ;
						cnt_q <= '0;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						state_q <= N_SQRT;
						cnt_q <= '0;
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= N_DLOAD;
						comp_q <= '0;
					end
				end
				N_DLOAD: begin
					state_q <= N_DSTEP;
					cnt_q <= '0;
				end
				N_DSTEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QW - 1)) begin
						if (comp_q == 2'd2) begin
							state_q <= N_DONE;
						end else begin
							comp_q <= comp_q + 2'd1;
							state_q <= N_DLOAD;
						end
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (state_q)
			N_IDLE: begin
				if (start) begin
					av_q[0] <= a_vec.x; av_q[1] <= a_vec.y; av_q[2] <= a_vec.z;
					bv_q[0] <= b_vec.x; bv_q[1] <= b_vec.y; bv_q[2] <= b_vec.z;
				end
			end
			N_CROSS: begin
				// Each component takes the first product, then subtracts the second.
				if (cnt_q != '0) begin
					if (!jj[0]) begin
						s_q[acc_idx] <= SW'(prod_q);
					end else begin
						s_q[acc_idx] <= s_q[acc_idx] - SW'(prod_q);
					end
				end
			end
			N_ABS: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= s_q[i][SW-1];
					mag_q[i] <= s_q[i][SW-1] ? SW'(-s_q[i]) : SW'(s_q[i]);
					res_q[i] <= '0;
				end
				q_q <= '0;
			end
			N_SHIFT: begin
				if (big) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
			end
			N_SQ: begin
				if (cnt_q != '0) begin
					q_q <= q_q + 64'(prod_q);
				end
				rem_q <= '0;
				root_q <= '0;
			end
			N_SQRT: begin
				// One result bit of the integer square root per cycle.
				q_q <= q_q << 2;
				if (rem2 >= trial) begin
					rem_q <= 34'(rem2 - trial);
					root_q <= {root_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem2[33:0];
					root_q <= {root_q[NW-2:0], 1'b0};
				end
			end
			N_DLOAD: begin
				num_q <= numer;
				drem_q <= NW'(numer[NUM_W-1:QW]);
				quo_q <= '0;
			end
			N_DSTEP: begin
				num_q <= num_q << 1;
				drem_q <= qbit ? NW'(drem2 - {1'b0, root_q}) : NW'(drem2);
				quo_q <= qf[QW-2:0];
				if (cnt_q == 5'(QW - 1)) begin
					res_q[comp_q] <= neg_q[comp_q] ? -gvns_pkg::NRM_W'(qc) :
						gvns_pkg::NRM_W'(qc);
				end
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == N_DONE);
	assign result.x = res_q[0];
	assign result.y = res_q[1];
	assign result.z = res_q[2];

endmodule

/* rtl/core/grid_vertex_normal_stream_unit.sv */
// Grid vertex normal stream: top level with the item sequencer and output register.
// Depends on gvns_pkg, gvns_ring and gvns_norm.
//
// Vertices of a row-major grid enter on the in_valid/in_ready channel, one
// word per vertex. Unit normals leave on the out_valid/out_ready channel in
// vertex order, one row behind the input; the word flagged final_vertex also
// flushes the normals of the last row, and run_end marks the last result
// word caused by an input word. cfg_wr_en/cfg_wr_data set the row length.
// The block takes one vertex at a time. Accepting a vertex, reducing its
// column and writing it back pass through S_IDLE, S_REDUCE, S_PLAN and
// S_COMMIT, with S_REDUCE repeated for each subtraction of the row length
// from the column. Each normal is built in steps: fetch its five points from
// the ring, one per cycle, run the shared arithmetic unit (cross product, up
// to 18 scaling shifts, 32-step square root and three 15-step divisions) and
// emit. A zero cross sum leaves the unit straight after the cross product,
// and a vertex without a neighbor pair goes from setup to emit directly.
// While the output register holds a word that the receiver has not taken,
// the sequencer waits before emitting the next one. Reset sets the row
// length to 32 and starts a new grid; the ring store is not cleared.
module grid_vertex_normal_stream_unit #(
	parameter int MAX_ROW_LENGTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [5:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gvns_pkg::coord_t     vertex_x,
	input  gvns_pkg::coord_t     vertex_y,
	input  gvns_pkg::coord_t     vertex_z,
	input  logic                 final_vertex,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gvns_pkg::nrm_t       normal_x,
	output gvns_pkg::nrm_t       normal_y,
	output gvns_pkg::nrm_t       normal_z,
	output logic [15:0]          vertex_number,
	output logic                 run_end
);

	localparam int RING = 2 * MAX_ROW_LENGTH;
	localparam int AW   = $clog2(RING);
	localparam int LW   = $clog2(MAX_ROW_LENGTH + 1);
	localparam int DW   = $clog2(RING + 1);
	localparam int XW   = AW + 2;
	localparam int FW   = gvns_pkg::FILL_W + 1;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_REDUCE = 9'b000000010,
		S_PLAN   = 9'b000000100,
		S_SETUP  = 9'b000001000,
		S_FETCH  = 9'b000010000,
		S_BUILD  = 9'b000100000,
		S_WAIT   = 9'b001000000,
		S_EMIT   = 9'b010000000,
		S_COMMIT = 9'b100000000
	} state_t;

	state_t state_q;
	logic [gvns_pkg::RL_W-1:0] row_len_q;
	logic [LW-1:0] col_q, colr_q, len_q;
	logic [15:0] vc_q;
	logic [gvns_pkg::FILL_W-1:0] fill_q, fillc_q;
	logic [AW-1:0] ws_q;
	gvns_pkg::coord3_t cur_q;
	logic fin_q;
	logic [DW-1:0] d_q;
	logic pre_q, fb_q, fr_q, fl_q, up_q;
	logic [2:0] k_q;
	logic zero_s1;
	gvns_pkg::coord3_t pts_q [5];

	logic out_valid_q, run_end_q;
	gvns_pkg::nrm3_t out_nrm_q;
	logic [15:0] vnum_q;

	logic [LW-1:0] len_c, cnt_c, cd_c;
	logic [LW:0] cd_sum;
	logic [gvns_pkg::FILL_W-1:0] fill_c;
	logic fb_c, fr_c, fl_c;
	logic [XW-1:0] dist_c, slot_sum;
	logic [AW-1:0] slot_c;
	gvns_pkg::coord3_t rd_data, pa, pb, pr, pl;
	gvns_pkg::edge3_t a_vec, b_vec;
	gvns_pkg::nrm3_t norm_res;
	logic norm_start, norm_done, more, rd_en, wr_en;

	// Row length limited to the supported range.
	always_comb begin
		if (row_len_q < 6'd2) begin
			len_c = LW'(2);
		end else if (row_len_q > 6'(MAX_ROW_LENGTH)) begin
			len_c = LW'(MAX_ROW_LENGTH);
		end else begin
			len_c = row_len_q[LW-1:0];
		end
		fill_c = (fill_q == gvns_pkg::FILL_MAX) ? gvns_pkg::FILL_MAX :
			fill_q + 8'd1;
		cnt_c = (FW'(fillc_q) < FW'(len_q)) ? LW'(fillc_q) : len_q;
	end

	// Neighbor flags of the vertex d_q positions back.
	always_comb begin
		cd_sum = (LW+1)'(colr_q) + (LW+1)'(len_q) - (LW+1)'(d_q);
		cd_c = (cd_sum >= (LW+1)'(len_q)) ? LW'(cd_sum - (LW+1)'(len_q)) :
			LW'(cd_sum);
		fb_c = (FW'(d_q) + FW'(len_q)) < FW'(fillc_q);
		fr_c = (d_q != '0) && ((LW+1)'(cd_c) + (LW+1)'(1) != (LW+1)'(len_q));
		fl_c = (cd_c != '0) && ((FW'(d_q) + FW'(1)) < FW'(fillc_q));
	end

	// Ring slot of the point fetched in this cycle: current, forward,
	// backward, right, left.
	always_comb begin
		case (k_q)
			3'd0: dist_c = XW'(d_q);
			3'd1: dist_c = XW'(d_q) - XW'(len_q);
			3'd2: dist_c = XW'(d_q) + XW'(len_q);
			3'd3: dist_c = XW'(d_q) - XW'(1);
			default: dist_c = XW'(d_q) + XW'(1);
		endcase
		slot_sum = XW'(ws_q) + XW'(RING) - dist_c;
		slot_c = (slot_sum >= XW'(RING)) ? AW'(slot_sum - XW'(RING)) : AW'(slot_sum);
	end

	// Edge vectors; a missing neighbor is replaced by the vertex itself.
	always_comb begin
		pa = pre_q ? pts_q[1] : pts_q[0];
		pb = fb_q ? pts_q[2] : pts_q[0];
		pr = fr_q ? pts_q[3] : pts_q[0];
		pl = fl_q ? pts_q[4] : pts_q[0];
		a_vec.x = gvns_pkg::EDGE_W'(pa.x) - gvns_pkg::EDGE_W'(pb.x);
		a_vec.y = gvns_pkg::EDGE_W'(pa.y) - gvns_pkg::EDGE_W'(pb.y);
		a_vec.z = gvns_pkg::EDGE_W'(pa.z) - gvns_pkg::EDGE_W'(pb.z);
		b_vec.x = gvns_pkg::EDGE_W'(pr.x) - gvns_pkg::EDGE_W'(pl.x);
		b_vec.y = gvns_pkg::EDGE_W'(pr.y) - gvns_pkg::EDGE_W'(pl.y);
		b_vec.z = gvns_pkg::EDGE_W'(pr.z) - gvns_pkg::EDGE_W'(pl.z);
	end

	assign in_ready = (state_q == S_IDLE);
	assign norm_start = (state_q == S_BUILD);
	assign rd_en = (state_q == S_FETCH) && (k_q != 3'd5);
	assign wr_en = (state_q == S_COMMIT);
	assign more = (pre_q && fin_q) || (!pre_q && d_q != '0);

	gvns_ring #(
		.DEPTH(RING),
		.AW(AW)
	) u_ring (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(ws_q),
		.wr_data(cur_q),
		.rd_en(rd_en),
		.rd_addr(slot_c),
		.rd_data(rd_data)
	);

	gvns_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(norm_start),
		.a_vec(a_vec),
		.b_vec(b_vec),
		.done(norm_done),
		.result(norm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_len_q <= gvns_pkg::ROW_LEN_RESET;
			col_q <= '0;
			vc_q <= '0;
			fill_q <= '0;
			ws_q <= '0;
			out_valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				row_len_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (colr_q < len_q) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					if (FW'(fillc_q) > FW'(len_q) || fin_q) begin
						state_q <= S_SETUP;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_SETUP: begin
					k_q <= '0;
					if (!((pre_q || fb_c) && (fr_c || fl_c))) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd5) begin
						state_q <= S_BUILD;
					end
				end
				S_BUILD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (norm_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= more ? S_SETUP : S_COMMIT;
					end
				end
				S_COMMIT: begin
					ws_q <= (ws_q == AW'(RING - 1)) ? '0 : ws_q + AW'(1);
					if (fin_q) begin
						col_q <= '0;
						vc_q <= '0;
						fill_q <= '0;
					end else begin
						col_q <= ((LW+1)'(colr_q) + (LW+1)'(1) >= (LW+1)'(len_q)) ? '0 :
							colr_q + LW'(1);
						vc_q <= vc_q + 16'd1;
						fill_q <= fillc_q;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q.x <= vertex_x;
				cur_q.y <= vertex_y;
				cur_q.z <= vertex_z;
				fin_q <= final_vertex;
				len_q <= len_c;
				colr_q <= col_q;
				fillc_q <= fill_c;
			end
			S_REDUCE: begin
				// The column count may exceed a row length written mid-grid.
				if (colr_q >= len_q) begin
					colr_q <= colr_q - len_q;
				end
			end
			S_PLAN: begin
				if (FW'(fillc_q) > FW'(len_q)) begin
					d_q <= DW'(len_q);
					pre_q <= 1'b1;
				end else begin
					d_q <= DW'(cnt_c) - DW'(1);
					pre_q <= 1'b0;
				end
			end
			S_SETUP: begin
				fb_q <= fb_c;
				fr_q <= fr_c;
				fl_q <= fl_c;
				up_q <= !((pre_q || fb_c) && (fr_c || fl_c));
			end
			S_FETCH: begin
				zero_s1 <= (dist_c == '0);
				if (k_q != 3'd0) begin
					pts_q[k_q - 3'd1] <= zero_s1 ? cur_q : rd_data;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					if (up_q) begin
						out_nrm_q.x <= '0;
						out_nrm_q.y <= '0;
						out_nrm_q.z <= gvns_pkg::NRM_W'(gvns_pkg::ONE_Q14);
					end else begin
						out_nrm_q <= norm_res;
					end
					vnum_q <= vc_q - 16'(d_q);
					run_end_q <= !more;
					if (pre_q && fin_q) begin
						pre_q <= 1'b0;
						d_q <= DW'(cnt_c) - DW'(1);
					end else if (!pre_q && d_q != '0) begin
						d_q <= d_q - DW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign normal_x = out_nrm_q.x;
	assign normal_y = out_nrm_q.y;
	assign normal_z = out_nrm_q.z;
	assign vertex_number = vnum_q;
	assign run_end = run_end_q;

endmodule
